// ===== rtl/core/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/tpfr_pkg.sv =====
`timescale 1ns / 1ps

package tpfr_pkg;

    typedef enum logic [2:0] {
        REG_ZERO_LEVEL    = 3'd0,
        REG_HYSTERESIS    = 3'd1,
        REG_PERIOD        = 3'd2,
        REG_MIN_DELAY     = 3'd3,
        REG_MAX_DELAY     = 3'd4,
        REG_LOW_LIMIT     = 3'd5,
        REG_HIGH_LIMIT    = 3'd6,
        REG_MIN_CURRENT   = 3'd7
    } t_reg_index;

    localparam logic [1:0]  OUT_CHANNEL     = 2'd3;
    localparam logic [11:0] PHASE_OFFSET    = 12'd511;
    localparam logic [11:0] OUT_OFFSET      = 12'd255;
    localparam logic [7:0]  EDGE_MAX        = 8'd255;
    localparam logic [7:0]  EDGE_WIN_LO     = 8'd4;
    localparam logic [7:0]  EDGE_WIN_HI     = 8'd11;
    localparam logic [9:0]  CURRENT_MARGIN  = 10'd26;
    localparam logic [9:0]  BIG_STEP        = 10'd3;
    localparam logic [20:0] HIGH_MARGIN     = 21'd30;

    localparam logic signed [9:0] RST_ZERO_LEVEL  = 10'sd10;
    localparam logic [7:0]        RST_HYSTERESIS  = 8'd15;
    localparam logic [7:0]        RST_PERIOD      = 8'd75;
    localparam logic [7:0]        RST_MIN_DELAY   = 8'd47;
    localparam logic [7:0]        RST_MAX_DELAY   = 8'd180;
    localparam logic [17:0]       RST_LOW_LIMIT   = 18'd17250;
    localparam logic [17:0]       RST_HIGH_LIMIT  = 18'd19125;
    localparam logic [9:0]        RST_MIN_CURRENT = 10'd40;
    localparam logic [7:0]        RST_DELAY       = 8'd47;

endpackage

// ===== rtl/core/three_phase_firing_regulator.sv =====
// three-phase firing regulator
// input channel: i_sample_valid / o_sample_ready carry one 10-bit converter sample per
// transaction, in a fixed channel rotation 0, 1, 2, 3, 0, ... starting at channel 0
// output channel: o_result_valid / i_result_ready carry one result per input sample:
// channel, offset-removed value, fire request with phase and delay, enable, leds,
// and at the end of a regulation period the delay step report and edge count
// latency: a result is valid the cycle after its sample is accepted
// throughput: one sample per cycle while the receiver takes results, set by the single output register
// o_sample_ready is high whenever the output register is empty or being drained,
// so a stalled receiver holds the current result and stalls the input one-for-one
// configuration: apb registers at byte address 4*i, written with psel, penable,
// pwrite high; pready is always high and prdata returns the register contents
// reset (synchronous, active low): rotation back to channel 0, edge and sum state
// cleared, firing enabled, delay setting 47, leds off, registers to defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module three_phase_firing_regulator
    import tpfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sample_valid,
    output logic               o_sample_ready,
    input  logic [9:0]         i_sample,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic [1:0]         o_channel,
    output logic signed [10:0] o_stored_value,
    output logic               o_fire_request,
    output logic [1:0]         o_fire_phase,
    output logic [7:0]         o_fire_delay,
    output logic               o_enabled,
    output logic               o_green_led,
    output logic               o_red_led,
    output logic               o_period_done,
    output logic [7:0]         o_delay_setting,
    output logic               o_delay_changed,
    output logic [7:0]         o_edge_report,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic signed [9:0]  r_zero_level;
    logic [7:0]         r_hysteresis;
    logic [7:0]         r_period_samples;
    logic [7:0]         r_min_delay;
    logic [7:0]         r_max_delay;
    logic [17:0]        r_low_limit;
    logic [17:0]        r_high_limit;
    logic [9:0]         r_min_current;

    logic [1:0]         r_next_channel;
    logic [2:0]         r_rising_seen;
    logic [2:0]         r_falling_seen;
    logic [7:0]         r_edge_count;
    logic signed [19:0] r_voltage_sum;
    logic [7:0]         r_sample_count;
    logic               r_enable_flag;
    logic [7:0]         r_delay_value;
    logic [7:0]         r_reported_delay;
    logic [1:0]         r_led_levels;

    logic               r_out_valid;
    logic [1:0]         r_channel;
    logic signed [10:0] r_stored_value;
    logic               r_fire_request;
    logic [1:0]         r_fire_phase;
    logic [7:0]         r_fire_delay;
    logic               r_period_done;
    logic               r_delay_changed;
    logic [7:0]         r_edge_report;

    logic [2:0]         n_rising_seen;
    logic [2:0]         n_falling_seen;
    logic [7:0]         n_edge_count;
    logic signed [19:0] n_voltage_sum;
    logic [7:0]         n_sample_count;
    logic               n_enable_flag;
    logic [7:0]         n_delay_value;
    logic [7:0]         n_reported_delay;
    logic [1:0]         n_led_levels;
    logic signed [10:0] n_stored_value;
    logic               n_fire_request;
    logic [1:0]         n_fire_phase;
    logic [7:0]         n_fire_delay;
    logic               n_period_done;
    logic               n_delay_changed;
    logic [7:0]         n_edge_report;

    logic               in_accept;
    logic               cfg_write;
    t_reg_index         reg_index;

    logic signed [11:0] raw;
    logic signed [11:0] value;
    logic signed [11:0] band_hi;
    logic signed [11:0] band_lo;
    logic               edge_hit;
    logic signed [20:0] sum_ext;
    logic               en;
    logic [9:0]         d;
    logic [9:0]         mn;

    assign pready         = 1'b1;
    assign cfg_write      = psel & penable & pwrite & pready;
    assign reg_index      = t_reg_index'(paddr[4:2]);
    assign o_sample_ready = !r_out_valid || i_result_ready;
    assign in_accept      = i_sample_valid && o_sample_ready;

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_ZERO_LEVEL:  prdata = {{22{r_zero_level[9]}}, r_zero_level};
            REG_HYSTERESIS:  prdata = {24'd0, r_hysteresis};
            REG_PERIOD:      prdata = {24'd0, r_period_samples};
            REG_MIN_DELAY:   prdata = {24'd0, r_min_delay};
            REG_MAX_DELAY:   prdata = {24'd0, r_max_delay};
            REG_LOW_LIMIT:   prdata = {14'd0, r_low_limit};
            REG_HIGH_LIMIT:  prdata = {14'd0, r_high_limit};
            REG_MIN_CURRENT: prdata = {22'd0, r_min_current};
        endcase
    end

    always_comb begin
        raw     = {2'b00, i_sample};
        band_hi = {{2{r_zero_level[9]}}, r_zero_level} + {4'd0, r_hysteresis};
        band_lo = {{2{r_zero_level[9]}}, r_zero_level} - {4'd0, r_hysteresis};

        n_rising_seen    = r_rising_seen;
        n_falling_seen   = r_falling_seen;
        n_edge_count     = r_edge_count;
        n_voltage_sum    = r_voltage_sum;
        n_sample_count   = r_sample_count;
        n_enable_flag    = r_enable_flag;
        n_delay_value    = r_delay_value;
        n_reported_delay = r_reported_delay;
        n_led_levels     = r_led_levels;
        n_fire_request   = 1'b0;
        n_fire_phase     = 2'd0;
        n_fire_delay     = 8'd0;
        n_period_done    = 1'b0;
        n_delay_changed  = 1'b0;
        n_edge_report    = 8'd0;
        edge_hit         = 1'b0;
        sum_ext          = '0;
        en               = 1'b0;
        d                = {2'b00, r_delay_value};
        mn               = {2'b00, r_min_delay};

        if (r_next_channel != OUT_CHANNEL) begin
            value = raw - PHASE_OFFSET;
            if (value > band_hi && !r_rising_seen[r_next_channel]) begin
                n_rising_seen[r_next_channel] = 1'b1;
                edge_hit = 1'b1;
                if (r_enable_flag) begin
                    n_fire_request = 1'b1;
                    n_fire_phase   = r_next_channel;
                    n_fire_delay   = r_delay_value;
                end
            end
            if (value < band_lo) begin
                n_rising_seen[r_next_channel] = 1'b0;
                if (!r_falling_seen[r_next_channel]) begin
                    n_falling_seen[r_next_channel] = 1'b1;
                    edge_hit = 1'b1;
                end
            end
            if (value > band_hi) begin
                n_falling_seen[r_next_channel] = 1'b0;
            end
            if (edge_hit && r_edge_count != EDGE_MAX) begin
                n_edge_count = r_edge_count + 8'd1;
            end
        end else begin
            value          = raw - OUT_OFFSET;
            n_voltage_sum  = r_voltage_sum + {{8{value[11]}}, value};
            n_sample_count = r_sample_count + 8'd1;
            if (n_sample_count >= r_period_samples) begin
                sum_ext = {n_voltage_sum[19], n_voltage_sum};
                en = (r_edge_count > EDGE_WIN_LO) && (r_edge_count < EDGE_WIN_HI);
                if (sum_ext < signed'({11'd0, r_min_current}) && d > mn + CURRENT_MARGIN) begin
                    en = 1'b0;
                end
                if (en) begin
                    n_led_levels = 2'b00;
                end else begin
                    n_led_levels = 2'b11;
                    d = mn;
                end
                if (sum_ext < signed'({3'd0, r_low_limit})) begin
                    if (d < {2'b00, r_max_delay}) begin
                        d = d + 10'd1;
                    end
                    n_led_levels[0] = 1'b1;
                end
                if (sum_ext > signed'({3'd0, r_high_limit})) begin
                    if (d > mn) begin
                        d = d - 10'd1;
                    end
                    n_led_levels[1] = 1'b1;
                end
                if (sum_ext > signed'({3'd0, r_high_limit} + HIGH_MARGIN)
                    && d > mn + BIG_STEP) begin
                    d = d - BIG_STEP;
                end
                n_enable_flag    = en;
                n_delay_value    = d[7:0];
                n_delay_changed  = d[7:0] != r_reported_delay;
                n_reported_delay = d[7:0];
                n_edge_report    = r_edge_count;
                n_period_done    = 1'b1;
                n_sample_count   = 8'd0;
                n_voltage_sum    = '0;
                n_edge_count     = 8'd0;
            end
        end
        n_stored_value = value[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_level     <= RST_ZERO_LEVEL;
            r_hysteresis     <= RST_HYSTERESIS;
            r_period_samples <= RST_PERIOD;
            r_min_delay      <= RST_MIN_DELAY;
            r_max_delay      <= RST_MAX_DELAY;
            r_low_limit      <= RST_LOW_LIMIT;
            r_high_limit     <= RST_HIGH_LIMIT;
            r_min_current    <= RST_MIN_CURRENT;
            r_next_channel   <= 2'd0;
            r_rising_seen    <= 3'd0;
            r_falling_seen   <= 3'd0;
            r_edge_count     <= 8'd0;
            r_voltage_sum    <= '0;
            r_sample_count   <= 8'd0;
            r_enable_flag    <= 1'b1;
            r_delay_value    <= RST_DELAY;
            r_reported_delay <= 8'd0;
            r_led_levels     <= 2'b00;
            r_out_valid      <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (reg_index)
                    REG_ZERO_LEVEL:  r_zero_level     <= signed'(pwdata[9:0]);
                    REG_HYSTERESIS:  r_hysteresis     <= pwdata[7:0];
                    REG_PERIOD:      r_period_samples <= pwdata[7:0];
                    REG_MIN_DELAY:   r_min_delay      <= pwdata[7:0];
                    REG_MAX_DELAY:   r_max_delay      <= pwdata[7:0];
                    REG_LOW_LIMIT:   r_low_limit      <= pwdata[17:0];
                    REG_HIGH_LIMIT:  r_high_limit     <= pwdata[17:0];
                    REG_MIN_CURRENT: r_min_current    <= pwdata[9:0];
                endcase
            end
            if (in_accept) begin
                r_next_channel   <= r_next_channel + 2'd1;
                r_rising_seen    <= n_rising_seen;
                r_falling_seen   <= n_falling_seen;
                r_edge_count     <= n_edge_count;
                r_voltage_sum    <= n_voltage_sum;
                r_sample_count   <= n_sample_count;
                r_enable_flag    <= n_enable_flag;
                r_delay_value    <= n_delay_value;
                r_reported_delay <= n_reported_delay;
                r_led_levels     <= n_led_levels;
                r_out_valid      <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid      <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_channel       <= r_next_channel;
            r_stored_value  <= n_stored_value;
            r_fire_request  <= n_fire_request;
            r_fire_phase    <= n_fire_phase;
            r_fire_delay    <= n_fire_delay;
            r_period_done   <= n_period_done;
            r_delay_changed <= n_delay_changed;
            r_edge_report   <= n_edge_report;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_channel       = r_channel;
    assign o_stored_value  = r_stored_value;
    assign o_fire_request  = r_fire_request;
    assign o_fire_phase    = r_fire_phase;
    assign o_fire_delay    = r_fire_delay;
    assign o_enabled       = r_enable_flag;
    assign o_green_led     = r_led_levels[0];
    assign o_red_led       = r_led_levels[1];
    assign o_period_done   = r_period_done;
    assign o_delay_setting = r_delay_value;
    assign o_delay_changed = r_delay_changed;
    assign o_edge_report   = r_edge_report;

    `ASSERT_IMPLY(a_fire_when_enabled, i_clk, i_rst_n, o_result_valid && o_fire_request, o_enabled && o_channel != OUT_CHANNEL, "fire request while disabled or on output channel")
    `ASSERT_IMPLY(a_period_on_out, i_clk, i_rst_n, o_result_valid && o_period_done, o_channel == OUT_CHANNEL, "period end on a phase channel")
    `ASSERT_IMPLY(a_change_at_period, i_clk, i_rst_n, o_result_valid && o_delay_changed, o_period_done, "delay change outside period end")
    `ASSERT_NEXT(a_rotation, i_clk, i_rst_n, in_accept, r_next_channel == $past(r_next_channel) + 2'd1 && o_channel == $past(r_next_channel), "channel rotation broken")

endmodule
